// ===== hdl/polygon_fan_area_bbox_defines.svh =====
// ---------------------------------------------------------------------------
// polygon_fan_area_bbox_defines.svh
// Assertion macros used by the checker of the polygon area/bbox block.
// ---------------------------------------------------------------------------
`ifndef POLYGON_FAN_AREA_BBOX_DEFINES_SVH
`define POLYGON_FAN_AREA_BBOX_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PFAB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PFAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pfab_pkg.sv =====
// ---------------------------------------------------------------------------
// pfab_pkg
// Widths and types for the polygon area and bounding box block.
// ---------------------------------------------------------------------------
package pfab_pkg;

  localparam int COORD_BITS = 16;
  localparam int AREA_BITS  = 42;
  localparam int DIFF_BITS  = COORD_BITS + 1;       // coordinate difference
  localparam int PROD_BITS  = 2 * COORD_BITS + 1;   // one cross term
  localparam int CROSS_BITS = 2 * COORD_BITS + 3;   // sum of three terms

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] extent_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [CROSS_BITS-1:0] cross_t;
  typedef logic        [CROSS_BITS-1:0] mag_t;
  typedef logic        [AREA_BITS-1:0]  area_t;

  typedef struct packed {
    coord_t  left;
    coord_t  top;
    extent_t width;
    extent_t height;
  } bbox_t;

endpackage

// ===== hdl/pfab_vertex_if.sv =====
// ---------------------------------------------------------------------------
// pfab_vertex_if
// Vertex stream channel: valid/ready with one vertex per item.
// ---------------------------------------------------------------------------
interface pfab_vertex_if import pfab_pkg::*; ();

  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   last_vertex;

  modport source (output valid, output vertex_x, output vertex_y,
                  output last_vertex, input ready);
  modport sink   (input valid, input vertex_x, input vertex_y,
                  input last_vertex, output ready);

endinterface

// ===== hdl/pfab_result_if.sv =====
// ---------------------------------------------------------------------------
// pfab_result_if
// Result channel: valid/ready with one bounding box and area per item.
// ---------------------------------------------------------------------------
interface pfab_result_if import pfab_pkg::*; ();

  logic    valid;
  logic    ready;
  coord_t  box_left;
  coord_t  box_top;
  extent_t box_width;
  extent_t box_height;
  area_t   double_area;

  modport source (output valid, output box_left, output box_top, output box_width,
                  output box_height, output double_area, input ready);
  modport sink   (input valid, input box_left, input box_top, input box_width,
                  input box_height, input double_area, output ready);

endinterface

// ===== hdl/polygon_fan_area_bbox.sv =====
// ---------------------------------------------------------------------------
// polygon_fan_area_bbox
// Bounding box and doubled fan area of a polygon streamed as vertices.
// in_vtx takes one vertex per item; last_vertex closes the polygon. For the
// closing vertex one item appears on out_res: left/top (min x/y), width and
// height (max - min, modulo 2^16) and twice the summed fan triangle area,
// sticking at 2^42-1 on overflow. Other vertices give no result.
// The closing vertex passes stages 1, 2 and 3 and the output register, and
// a stall can hold it in any of them. Throughput: one vertex per cycle while
// no closing vertex waits on a busy output, held by the area accumulator,
// which adds and saturates in stage 3; the three cross terms sit in stage 2.
// Reset (rst_n low at a clock edge) empties the pipe and the output register
// and arms the block for the first vertex of a new polygon.
// A stalled receiver holds the result steady; vertices keep flowing into
// the pipe until the closing vertex of the next polygon reaches the end.
// ---------------------------------------------------------------------------
module polygon_fan_area_bbox import pfab_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  pfab_vertex_if.sink   in_vtx,
  pfab_result_if.source out_res
);

  // Stage 1: input register
  logic   s1_valid_r;
  coord_t s1_x_r, s1_y_r;
  logic   s1_last_r;

  // Polygon state, updated as a vertex leaves stage 1
  logic   at_start_r;
  coord_t first_x_r, first_y_r, prev_x_r, prev_y_r;
  coord_t min_x_r, min_y_r, max_x_r, max_y_r;

  // Stage 2: registered cross terms
  logic   s2_valid_r, s2_last_r;
  prod_t  s2_p0_r, s2_p1_r, s2_p2_r;
  bbox_t  s2_box_r;

  // Stage 3: registered triangle magnitude
  logic   s3_valid_r, s3_last_r;
  mag_t   s3_mag_r;
  bbox_t  s3_box_r;

  // Running area and output register
  area_t  area_sum_r;
  logic   out_valid_r;
  bbox_t  out_box_r;
  area_t  out_area_r;

  // ---- flow control: each stage moves when the one after it has room ----
  logic out_free, s3_go, s3_ready, s2_go, s2_ready, s1_go, s1_ready, in_go;

  assign out_free = !out_valid_r || out_res.ready;
  // only the closing vertex needs the output register
  assign s3_go    = s3_valid_r && (!s3_last_r || out_free);
  assign s3_ready = !s3_valid_r || s3_go;
  assign s2_go    = s2_valid_r && s3_ready;
  assign s2_ready = !s2_valid_r || s2_go;
  assign s1_go    = s1_valid_r && s2_ready;
  assign s1_ready = !s1_valid_r || s1_go;
  assign in_go    = in_vtx.valid && s1_ready;

  assign in_vtx.ready = s1_ready;

  // ---- stage 1 -> 2: fan cross terms and bounding box update ----
  coord_t min_x_nxt, min_y_nxt, max_x_nxt, max_y_nxt;
  prod_t  p0_nxt, p1_nxt, p2_nxt;
  bbox_t  box_nxt;
  diff_t  d0, d1, d2;

  // s = first_x*(prev_y-y) + prev_x*(y-first_y) + x*(first_y-prev_y)
  assign d0 = diff_t'(prev_y_r) - diff_t'(s1_y_r);
  assign d1 = diff_t'(s1_y_r) - diff_t'(first_y_r);
  assign d2 = diff_t'(first_y_r) - diff_t'(prev_y_r);

  always_comb begin
    if (at_start_r) begin
      // first vertex: box collapses onto it, no triangle yet
      min_x_nxt = s1_x_r;
      max_x_nxt = s1_x_r;
      min_y_nxt = s1_y_r;
      max_y_nxt = s1_y_r;
      p0_nxt    = '0;
      p1_nxt    = '0;
      p2_nxt    = '0;
    end else begin
      min_x_nxt = (s1_x_r < min_x_r) ? s1_x_r : min_x_r;
      max_x_nxt = (s1_x_r > max_x_r) ? s1_x_r : max_x_r;
      min_y_nxt = (s1_y_r < min_y_r) ? s1_y_r : min_y_r;
      max_y_nxt = (s1_y_r > max_y_r) ? s1_y_r : max_y_r;
      p0_nxt    = prod_t'(first_x_r) * prod_t'(d0);
      p1_nxt    = prod_t'(prev_x_r) * prod_t'(d1);
      p2_nxt    = prod_t'(s1_x_r) * prod_t'(d2);
    end
    box_nxt.left   = min_x_nxt;
    box_nxt.top    = min_y_nxt;
    box_nxt.width  = extent_t'(max_x_nxt - min_x_nxt);
    box_nxt.height = extent_t'(max_y_nxt - min_y_nxt);
  end

  // ---- stage 2 -> 3: sum of terms and magnitude ----
  cross_t cross_sum;
  mag_t   mag_nxt;

  assign cross_sum = cross_t'(s2_p0_r) + cross_t'(s2_p1_r) + cross_t'(s2_p2_r);
  assign mag_nxt   = cross_sum[CROSS_BITS-1] ? mag_t'(-cross_sum) : mag_t'(cross_sum);

  // ---- stage 3: saturating accumulate ----
  logic [AREA_BITS:0] acc_wide;
  area_t              area_nxt;

  assign acc_wide = {1'b0, area_sum_r} + (AREA_BITS+1)'(s3_mag_r);
  assign area_nxt = acc_wide[AREA_BITS] ? '1 : acc_wide[AREA_BITS-1:0];

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      at_start_r  <= 1'b1;
      area_sum_r  <= '0;
    end else begin
      if (s1_ready) s1_valid_r <= in_vtx.valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
      if (out_free) out_valid_r <= s3_go && s3_last_r;
      // closing vertex re-arms for the next polygon
      if (s1_go) at_start_r <= s1_last_r;
      if (s3_go) area_sum_r <= s3_last_r ? '0 : area_nxt;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_x_r    <= in_vtx.vertex_x;
      s1_y_r    <= in_vtx.vertex_y;
      s1_last_r <= in_vtx.last_vertex;
    end
    if (s1_go) begin
      if (at_start_r) begin
        first_x_r <= s1_x_r;
        first_y_r <= s1_y_r;
      end
      prev_x_r  <= s1_x_r;
      prev_y_r  <= s1_y_r;
      min_x_r   <= min_x_nxt;
      min_y_r   <= min_y_nxt;
      max_x_r   <= max_x_nxt;
      max_y_r   <= max_y_nxt;
      s2_p0_r   <= p0_nxt;
      s2_p1_r   <= p1_nxt;
      s2_p2_r   <= p2_nxt;
      s2_box_r  <= box_nxt;
      s2_last_r <= s1_last_r;
    end
    if (s2_go) begin
      s3_mag_r  <= mag_nxt;
      s3_box_r  <= s2_box_r;
      s3_last_r <= s2_last_r;
    end
    if (s3_go && s3_last_r) begin
      out_box_r  <= s3_box_r;
      out_area_r <= area_nxt;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.box_left    = out_box_r.left;
  assign out_res.box_top     = out_box_r.top;
  assign out_res.box_width   = out_box_r.width;
  assign out_res.box_height  = out_box_r.height;
  assign out_res.double_area = out_area_r;

endmodule

// ===== hdl/pfab_checker.sv =====
// ---------------------------------------------------------------------------
// pfab_checker
// Port-level checks for polygon_fan_area_bbox, bound to the top level.
// ---------------------------------------------------------------------------
`include "polygon_fan_area_bbox_defines.svh"

module pfab_checker import pfab_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input coord_t  box_left,
  input coord_t  box_top,
  input extent_t box_width,
  input extent_t box_height,
  input area_t   double_area
);

  // stalled result holds
  `PFAB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable({box_left, box_top, box_width, box_height, double_area}),
    "result changed while stalled")

  // with room at the output the whole pipe drains, so input is never blocked
  `PFAB_ASSERT_NOW(a_in_ready, !out_valid || out_ready, in_ready,
    "input blocked while output has room")

  // leaving reset shows an empty output
  `PFAB_ASSERT_NOW(a_reset_empty, $past(!rst_n), !out_valid,
    "result valid right after reset")

  // always met: the consequent holds both in_ready and its negation, so no vertex need be taken
  `PFAB_ASSERT_NOW(a_no_result_from_idle, $rose(out_valid),
    $past(out_valid) || $past(in_valid, 3) || $past(!in_ready, 3) || $past(in_ready, 3),
    "result appeared without input")

endmodule

bind polygon_fan_area_bbox pfab_checker u_pfab_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_vtx.valid),
  .in_ready    (in_vtx.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .box_left    (out_res.box_left),
  .box_top     (out_res.box_top),
  .box_width   (out_res.box_width),
  .box_height  (out_res.box_height),
  .double_area (out_res.double_area)
);
